/* design/flnp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package flnp_pkg;

    localparam int NODES      = 64;
    localparam int IDX_W      = $clog2(NODES);
    localparam int LINK_W     = $clog2(NODES + 1);
    localparam int CNT_W      = $clog2(NODES + 1);
    localparam int VALUE_W    = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // link value that marks the end of a list
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2,
        OP_TRAV  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               idx_ok;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

/* design/flnp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module flnp_front
    import flnp_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [39:0]          s_tdata,   // node_index[5:0], value[37:6]
    input  wire logic [1:0]           s_tuser,   // kind[1:0]
    input  wire logic                 q_ready,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    logic [IDX_W-1:0] idx;

    assign idx      = s_tdata[IDX_W-1:0];
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    // decode kind, range-check the node index for free
    always_comb
    begin
        q_cmd.op     = op_t'(s_tuser);
        q_cmd.idx    = idx;
        q_cmd.idx_ok = (LINK_W'(idx) < NULL_LINK);
        q_cmd.value  = s_tdata[IDX_W +: VALUE_W];
    end

endmodule

`default_nettype wire

/* design/flnp_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module flnp_cmd_fifo
    import flnp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      ready,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    cmd_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign ready     = (cnt_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && ready;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/flnp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module flnp_back
    import flnp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire cmd_t          cmd,
    output logic               cmd_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,   // node_out[5:0], value_out[37:6], used_count[44:38]
    output logic [0:0]         m_tuser,   // status[0]
    output logic               m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // pool state
    logic [LINK_W-1:0]  free_head_reg, free_head_next;
    logic [LINK_W-1:0]  list_head_reg, list_head_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // operation in flight
    op_t                op_reg, op_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [LINK_W-1:0]  nxt_reg, nxt_next;
    logic [VALUE_W-1:0] val_hold_reg, val_hold_next;

    // pending result
    logic               res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_node_reg, res_node_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_last_reg, res_last_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg;
    logic [IDX_W-1:0]   out_node_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_load;

    // memories; link entries not yet written read as index + 1
    logic [LINK_W-1:0]  link_mem  [NODES];
    logic [VALUE_W-1:0] value_mem [NODES];
    logic [NODES-1:0]   link_vld_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [LINK_W-1:0]  link_rd_reg;
    logic [VALUE_W-1:0] value_rd_reg;
    logic               vld_rd_reg;
    logic [IDX_W-1:0]   addr_rd_reg;
    logic [LINK_W-1:0]  link_eff;

    logic               link_we;
    logic [IDX_W-1:0]   link_waddr;
    logic [LINK_W-1:0]  link_wdata;
    logic               value_we;

    assign link_eff = vld_rd_reg ? link_rd_reg : (LINK_W'(addr_rd_reg) + 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        list_head_next  = list_head_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        cur_next        = cur_reg;
        k_next          = k_reg;
        nxt_next        = nxt_reg;
        val_hold_next   = val_hold_reg;
        res_status_next = res_status_reg;
        res_node_next   = res_node_reg;
        res_value_next  = res_value_reg;
        res_last_next   = res_last_reg;
        cmd_pop         = 1'b0;
        out_load        = 1'b0;
        rd_addr         = cur_reg;
        link_we         = 1'b0;
        link_waddr      = cur_reg;
        link_wdata      = list_head_reg;
        value_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    op_next         = cmd.op;
                    val_hold_next   = cmd.value;
                    res_status_next = 1'b0;
                    res_node_next   = '0;
                    res_value_next  = '0;
                    res_last_next   = 1'b1;
                    case (cmd.op)
                        OP_ALLOC, OP_ADD:
                        begin
                            if (free_head_reg >= NULL_LINK)
                            begin
                                res_status_next = 1'b1;   // pool full
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                rd_addr    = free_head_reg[IDX_W-1:0];
                                cur_next   = free_head_reg[IDX_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        OP_FREE:
                        begin
                            if (cmd.idx_ok)
                            begin
                                link_we        = 1'b1;
                                link_waddr     = cmd.idx;
                                link_wdata     = free_head_reg;
                                free_head_next = LINK_W'(cmd.idx);
                                if (cnt_reg != '0)
                                begin
                                    cnt_next = cnt_reg - 1'b1;
                                end
                            end
                            state_next = S_OUT;
                        end
                        OP_TRAV:
                        begin
                            if (list_head_reg >= NULL_LINK)
                            begin
                                res_status_next = 1'b1;   // list empty
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                rd_addr    = list_head_reg[IDX_W-1:0];
                                cur_next   = list_head_reg[IDX_W-1:0];
                                k_next     = '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (op_reg == OP_TRAV)
                begin
                    res_status_next = 1'b0;
                    res_node_next   = cur_reg;
                    res_value_next  = value_rd_reg;
                    res_last_next   = (link_eff >= NULL_LINK) || (k_reg == IDX_W'(NODES - 1));
                    nxt_next        = link_eff;
                end
                else
                begin
                    // pop the free head: link of the popped node is the new head
                    free_head_next = link_eff;
                    if (cnt_reg < CNT_W'(NODES))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (op_reg == OP_ADD)
                    begin
                        value_we       = 1'b1;
                        link_we        = 1'b1;
                        link_waddr     = cur_reg;
                        link_wdata     = list_head_reg;
                        list_head_next = LINK_W'(cur_reg);
                    end
                    res_status_next = 1'b0;
                    res_node_next   = cur_reg;
                    res_value_next  = '0;
                    res_last_next   = 1'b1;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if ((op_reg == OP_TRAV) && !res_last_reg)
                    begin
                        cur_next   = nxt_reg[IDX_W-1:0];
                        rd_addr    = nxt_reg[IDX_W-1:0];
                        k_next     = k_reg + 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            list_head_reg <= NULL_LINK;
            cnt_reg       <= '0;
            op_reg        <= OP_ALLOC;
            out_valid_reg <= 1'b0;
            link_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            if (link_we)
            begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        k_reg          <= k_next;
        nxt_reg        <= nxt_next;
        val_hold_reg   <= val_hold_next;
        res_status_reg <= res_status_next;
        res_node_reg   <= res_node_next;
        res_value_reg  <= res_value_next;
        res_last_reg   <= res_last_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_node_reg   <= res_node_reg;
            out_value_reg  <= res_value_reg;
            out_last_reg   <= res_last_reg;
            out_cnt_reg    <= cnt_reg;
        end
    end

    // link memory, registered read
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[rd_addr];
        vld_rd_reg  <= link_vld_reg[rd_addr];
        addr_rd_reg <= rd_addr;
    end

    // value memory, registered read
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[cur_reg] <= val_hold_reg;
        end
        value_rd_reg <= value_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_cnt_reg, out_value_reg, out_node_reg};

endmodule

`default_nettype wire

/* design/free_list_node_pool.sv */
// free_list_node_pool: array-based free-list node allocator with one data list.
// Steps: free goes IDLE, OUT to the output register; allocate/add go IDLE, READ, OUT;
// traverse goes IDLE, READ, OUT to the first node, then READ, OUT per further node
// (one registered link/value read each). The back end serves one request at a time.
// Reset (rst_n, async, active low): empty pool, free list 0..NODES-1, empty list,
// count 0. No clearing pass; link entries not yet written read as index + 1.
`timescale 1ns / 1ps
`default_nettype none

module free_list_node_pool
    import flnp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // node_index[5:0], value[37:6], zero pad
    input  wire logic [1:0]  s_tuser,    // kind[1:0]
    // result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,    // node_out[5:0], value_out[37:6], used_count[44:38]
    output logic [0:0]       m_tuser,    // status[0]
    output logic             m_tlast     // last result of the request
);

    logic q_ready;
    logic q_push;
    cmd_t q_cmd;
    logic q_not_empty;
    logic q_pop;
    cmd_t q_head;

    // front: decode kind, check index
    flnp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // short command queue decoupling front from back
    flnp_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .ready     (q_ready),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    // back: link/value memories, list heads, result register
    flnp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

/* sim/free_list_node_pool_tb.sv */
`timescale 1ns / 1ps

module free_list_node_pool_tb;
    import flnp_pkg::*;

    // one result as the block reports it
    typedef struct packed {
        logic               status;
        logic [IDX_W-1:0]   node;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [CNT_W-1:0]   used;
    } pool_reply_t;

    // opening script row; typed rows carry their single result inline
    typedef struct {
        op_t                op;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        logic               status;
        logic [IDX_W-1:0]   node;
        logic [CNT_W-1:0]   used;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // node_index[5:0], value[37:6], zero pad
    logic [1:0]  s_tuser;     // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // node_out[5:0], value_out[37:6], used_count[44:38]
    logic [0:0]  m_tuser;     // status[0]
    logic        m_tlast;

    free_list_node_pool dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the pool: values, links, heads and the count.
    // value_set marks entries written by an add; walks never touch
    // an entry that was not written.
    // ---------------------------------------------------------------
    logic [VALUE_W-1:0] pool_value [NODES];
    logic [LINK_W-1:0]  pool_link  [NODES];
    bit                 value_set  [NODES];
    logic [LINK_W-1:0]  list_front;
    logic [LINK_W-1:0]  free_front;
    logic [CNT_W-1:0]   nodes_used;

    pool_reply_t        pool_replies[$];  // results still owed by the block
    logic [IDX_W-1:0]   handed_out[$];    // nodes given out and not yet freed

    // run statistics
    int op_seen[4];
    int full_hits;
    int empty_walks;
    int capped_walks;
    int floor_frees;
    int replies_checked;
    int mismatches;

    // stimulus knobs
    int send_idle_pct;
    int rcv_idle_pct;
    int stall_calls;
    bit filling;

    script_row_t opening_rows[15];

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void pool_reset();
        for (int i = 0; i < NODES; i++)
        begin
            pool_value[i] = '0;
            pool_link[i]  = LINK_W'(i + 1);
            value_set[i]  = 1'b0;
        end
        list_front = NULL_LINK;
        free_front = '0;
        nodes_used = '0;
    endfunction

    // pop the free-list head; NULL_LINK when the pool is exhausted
    function automatic logic [LINK_W-1:0] pop_free_node();
        logic [LINK_W-1:0] n;
        n = free_front;
        if (n >= NODES)
            return NULL_LINK;
        free_front = pool_link[n[IDX_W-1:0]];
        if (nodes_used < NODES)
            nodes_used++;
        return n;
    endfunction

    function automatic void note_reply(logic st, logic [LINK_W-1:0] node,
                                       logic [VALUE_W-1:0] v, logic lst);
        pool_reply_t r;
        r.status = st;
        r.node   = node[IDX_W-1:0];
        r.value  = v;
        r.last   = lst;
        r.used   = nodes_used;
        pool_replies.push_back(r);
    endfunction

    // advance the shadow pool by one request and queue what it owes
    function automatic void apply_pool_op(op_t op, logic [IDX_W-1:0] idx,
                                          logic [VALUE_W-1:0] v);
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] nxt;
        int steps;
        op_seen[int'(op)]++;
        case (op)
            OP_ALLOC, OP_ADD:
            begin
                n = pop_free_node();
                if (n == NULL_LINK)
                begin
                    full_hits++;
                    note_reply(1'b1, '0, '0, 1'b1);
                end
                else
                begin
                    if (op == OP_ADD)
                    begin
                        pool_value[n[IDX_W-1:0]] = v;
                        value_set[n[IDX_W-1:0]]  = 1'b1;
                        pool_link[n[IDX_W-1:0]]  = list_front;
                        list_front = n;
                    end
                    handed_out.push_back(n[IDX_W-1:0]);
                    note_reply(1'b0, n, '0, 1'b1);
                end
            end
            OP_FREE:
            begin
                // no double-free check; count floors at zero
                if (nodes_used == 0)
                    floor_frees++;
                else
                    nodes_used--;
                pool_link[idx] = free_front;
                free_front = LINK_W'(idx);
                for (int i = 0; i < handed_out.size(); i++)
                begin
                    if (handed_out[i] == idx)
                    begin
                        handed_out.delete(i);
                        break;
                    end
                end
                note_reply(1'b0, '0, '0, 1'b1);
            end
            OP_TRAV:
            begin
                n = list_front;
                if (n >= NODES)
                begin
                    empty_walks++;
                    note_reply(1'b1, '0, '0, 1'b1);
                end
                else
                begin
                    // walk stops at null or after NODES visits (cycles)
                    steps = 0;
                    while (n < NODES && steps < NODES)
                    begin
                        nxt = pool_link[n[IDX_W-1:0]];
                        steps++;
                        note_reply(1'b0, n, pool_value[n[IDX_W-1:0]],
                                   (nxt >= NODES) || (steps == NODES));
                        n = nxt;
                    end
                    if (steps == NODES)
                        capped_walks++;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // true when a walk from list_front only meets written entries
    function automatic bit walk_is_safe();
        logic [LINK_W-1:0] n;
        int steps;
        n = list_front;
        steps = 0;
        while (n < NODES && steps < NODES)
        begin
            if (!value_set[n[IDX_W-1:0]])
                return 1'b0;
            n = pool_link[n[IDX_W-1:0]];
            steps++;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
    endtask

    // Offer one request. Entered and left at a falling edge; the request
    // counts as taken at the rising edge where s_tready is seen high.
    task automatic put_request(op_t op, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, v, idx};
        do
            @(posedge clk);
        while (!s_tready);
        apply_pool_op(op, idx, v);
        @(negedge clk);
    endtask

    // Random request. Fill mood mostly adds, drain mood mostly frees
    // nodes that were handed out. Stray frees (any index, so double
    // frees and frees at zero count) only come in the last phase.
    task automatic random_request(int phase);
        op_t                op;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] v;
        int                 pick;
        pick = $urandom_range(99);
        if (filling)
        begin
            if (pick < 68)      op = OP_ADD;
            else if (pick < 80) op = OP_ALLOC;
            else if (pick < 85) op = OP_FREE;
            else                op = OP_TRAV;
        end
        else
        begin
            if (pick < 3)       op = OP_ADD;
            else if (pick < 6)  op = OP_ALLOC;
            else if (pick < 91) op = OP_FREE;
            else                op = OP_TRAV;
        end
        idx = IDX_W'($urandom);
        v   = $urandom;
        // a walk that would read an unwritten entry is swapped out
        if (op == OP_TRAV && !walk_is_safe())
            op = filling ? OP_ADD : OP_FREE;
        if (op == OP_FREE)
        begin
            if (handed_out.size() > 0 && (phase < 3 || $urandom_range(3) != 0))
                idx = handed_out[$urandom_range(handed_out.size() - 1)];
            else if (phase < 3)
                op = OP_ADD;
        end
        put_request(op, idx, v);
        if (filling && free_front >= NODES && $urandom_range(3) == 0)
            filling = 1'b0;
        else if (!filling && nodes_used == 0 && $urandom_range(2) == 0)
            filling = 1'b1;
    endtask

    // result side: random back-pressure, plus a long hold on demand
    initial
    begin : result_side
        int hold_left;
        int stalls_served;
        m_tready = 1'b0;
        hold_left = 0;
        stalls_served = 0;
        forever
        begin
            @(negedge clk);
            if (stall_calls != stalls_served)
            begin
                stalls_served = stall_calls;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // compare every taken result with the oldest one owed
    initial
    begin : result_check
        pool_reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                replies_checked++;
                if (pool_replies.size() == 0)
                    flag_mismatch("unrequested result", m_tdata[31:0], '0);
                else
                begin
                    want = pool_replies.pop_front();
                    if (m_tuser[0] !== want.status)
                        flag_mismatch("status", 32'(m_tuser[0]), 32'(want.status));
                    if (m_tdata[5:0] !== want.node)
                        flag_mismatch("node_out", 32'(m_tdata[5:0]), 32'(want.node));
                    if (m_tdata[37:6] !== want.value)
                        flag_mismatch("value_out", m_tdata[37:6], want.value);
                    if (m_tdata[44:38] !== want.used)
                        flag_mismatch("used_count", 32'(m_tdata[44:38]), 32'(want.used));
                    if (m_tlast !== want.last)
                        flag_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

    initial
    begin : watchdog
        #8_000_000;
        $display("watchdog expired at %0t ns with %0d results owed", $time,
                 pool_replies.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        send_idle_pct = 33;
        rcv_idle_pct  = 87;
        stall_calls   = 0;
        filling       = 1'b1;
        mismatches    = 0;
        pool_reset();

        // Opening script. Walks on an empty list, value extremes, a
        // free of a node still on the list, and the add right after it
        // that closes the list into a loop, so the last walk stops at
        // NODES visits.
        opening_rows = '{
            '{OP_TRAV,  6'd0,  32'h0000_0000, 1'b1, 1'b1, 6'd0, 7'd0},
            '{OP_ALLOC, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 6'd0, 7'd1},
            '{OP_ADD,   6'd0,  32'h7FFF_FFFF, 1'b1, 1'b0, 6'd1, 7'd2},
            '{OP_ADD,   6'd0,  32'h8000_0000, 1'b1, 1'b0, 6'd2, 7'd3},
            '{OP_ADD,   6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd3, 7'd4},
            '{OP_TRAV,  6'd0,  32'h0000_0000, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_FREE,  6'd0,  32'h0000_0000, 1'b1, 1'b0, 6'd0, 7'd3},
            '{OP_ADD,   6'd0,  32'h0000_0000, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_ALLOC, 6'd63, 32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_FREE,  6'd4,  32'h0000_0000, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_TRAV,  6'd0,  32'h0000_0000, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_ADD,   6'd63, 32'h5A5A_A5A5, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_FREE,  6'd2,  32'h0000_0000, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_ADD,   6'd0,  32'h0F0F_F0F0, 1'b0, 1'b0, 6'd0, 7'd0},
            '{OP_TRAV,  6'd0,  32'h0000_0000, 1'b0, 1'b0, 6'd0, 7'd0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
        begin
            put_request(opening_rows[i].op, opening_rows[i].idx, opening_rows[i].value);
            // a typed row owes exactly one result; it stands in for the shadow's
            if (opening_rows[i].typed)
                pool_replies[pool_replies.size() - 1] = '{opening_rows[i].status,
                    opening_rows[i].node, 32'd0, 1'b1, opening_rows[i].used};
        end

        // three idling phases: slow receiver, slow sender, full speed
        for (int phase = 1; phase <= 3; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 87;
                rcv_idle_pct  = 33;
            end
            else if (phase == 3)
            begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
                stall_calls++;   // long receiver hold while requests keep coming
            end
            repeat (52) random_request(phase);
        end
        s_tvalid <= 1'b0;

        while (pool_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("ran %0d requests (alloc %0d, free %0d, add %0d, walk %0d), %0d results",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3], op_seen[0],
                 op_seen[1], op_seen[2], op_seen[3], replies_checked);
        $display("pool full %0d, empty walks %0d, full-length walks %0d, frees at zero %0d",
                 full_hits, empty_walks, capped_walks, floor_frees);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
design/flnp_pkg.sv
design/flnp_front.sv
design/flnp_cmd_fifo.sv
design/flnp_back.sv
design/free_list_node_pool.sv
sim/free_list_node_pool_tb.sv
